### rtl/core/tls_sni_split_point_finder_defines.svh
// assertion macros for the tls sni split point finder
// no dependencies; included by the parser and the top level
`ifndef TLS_SNI_SPLIT_POINT_FINDER_DEFINES_SVH
`define TLS_SNI_SPLIT_POINT_FINDER_DEFINES_SVH

`ifndef SYNTHESIS
`define TLSSNI_ASSERT_ON(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tlssni assertion failed");
`define TLSSNI_ASSERT(lbl, prop) `TLSSNI_ASSERT_ON(lbl, clk_i, rst_ni, prop)
`else
`define TLSSNI_ASSERT_ON(lbl, clk, rstn, prop)
`define TLSSNI_ASSERT(lbl, prop)
`endif

`endif

### rtl/core/tlssni_pkg.sv
// shared types and constants for the tls sni split point finder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlssni_pkg;

  localparam int unsigned MaxPacket = 4096;

  localparam int unsigned FieldW  = 13;
  localparam int unsigned HttpW   = 14;
  localparam int unsigned TtlW    = 9;
  localparam int unsigned CfgW    = 14;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TLS_ENABLE  = 2'd0,
    CFG_HTTP_OFFSET = 2'd1,
    CFG_FIXED_OFFSET = 2'd2,
    CFG_DECOY_TTL   = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    RULE_NONE  = 2'd0,
    RULE_SNI   = 2'd1,
    RULE_HTTP  = 2'd2,
    RULE_FIXED = 2'd3
  } split_rule_e;

  localparam logic [31:0] MethodGet  = 32'h4745_5420;
  localparam logic [31:0] MethodPost = 32'h504F_5354;
  localparam logic [31:0] MethodHead = 32'h4845_4144;

  typedef struct packed {
    logic              tls_enable;
    logic [HttpW-1:0]  http_offset;
    logic [FieldW-1:0] fixed_offset;
    logic [TtlW-1:0]   decoy_ttl;
  } cfg_t;

  typedef struct packed {
    logic              do_split;
    logic [FieldW-1:0] split_offset;
    split_rule_e       split_rule;
    logic              send_decoy;
    logic              sni_found;
    logic [FieldW-1:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/tlssni_parser.sv
// byte-wise clienthello walker: position, leading bytes and sni offset
// depends on tlssni_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "tls_sni_split_point_finder_defines.svh"

module tlssni_parser #(
  parameter int unsigned MAX_PACKET = tlssni_pkg::MaxPacket,
  localparam int unsigned PosW = $clog2(MAX_PACKET + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      data_i,
  input  wire logic            last_i,
  output logic [PosW-1:0]      len_o,
  output logic [PosW-1:0]      sni_o,
  output logic [31:0]          leading_o
);

  localparam logic [3:0] PH_HEADER    = 4'd0;
  localparam logic [3:0] PH_SESS_SKIP = 4'd1;
  localparam logic [3:0] PH_CIPH_HI   = 4'd2;
  localparam logic [3:0] PH_CIPH_LO   = 4'd3;
  localparam logic [3:0] PH_CIPH_SKIP = 4'd4;
  localparam logic [3:0] PH_COMP_LEN  = 4'd5;
  localparam logic [3:0] PH_COMP_SKIP = 4'd6;
  localparam logic [3:0] PH_EXTS_HI   = 4'd7;
  localparam logic [3:0] PH_EXTS_LO   = 4'd8;
  localparam logic [3:0] PH_TYPE_HI   = 4'd9;
  localparam logic [3:0] PH_TYPE_LO   = 4'd10;
  localparam logic [3:0] PH_ELEN_HI   = 4'd11;
  localparam logic [3:0] PH_ELEN_LO   = 4'd12;
  localparam logic [3:0] PH_EXT_SKIP  = 4'd13;
  localparam logic [3:0] PH_SNI_HDR   = 4'd14;
  localparam logic [3:0] PH_DONE      = 4'd15;

  localparam logic [PosW-1:0] PosMax     = PosW'(MAX_PACKET);
  localparam logic [PosW-1:0] PosLead    = PosW'(4);
  localparam logic [PosW-1:0] PosType    = PosW'(0);
  localparam logic [PosW-1:0] PosVersion = PosW'(1);
  localparam logic [PosW-1:0] PosHsType  = PosW'(5);
  localparam logic [PosW-1:0] PosSessLen = PosW'(43);

  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      phase_q, phase_d;
  logic [15:0]     skip_q, skip_d;
  logic [7:0]      hi_q, hi_d;
  logic [31:0]     lead_q, lead_d;
  logic [PosW-1:0] sni_q, sni_d;
  logic            fail_q, fail_d;

  logic [3:0]  ph_eff;
  logic [15:0] skip_dec;
  logic        in_range;

  assign in_range = pos_q < PosMax;
  assign skip_dec = skip_q - 16'd1;

  // a finished skip moves on before the byte is used
  always_comb begin
    ph_eff = phase_q;
    if (skip_q == 16'd0) begin
      case (phase_q)
        PH_SESS_SKIP: ph_eff = PH_CIPH_HI;
        PH_CIPH_SKIP: ph_eff = PH_COMP_LEN;
        PH_COMP_SKIP: ph_eff = PH_EXTS_HI;
        PH_EXT_SKIP:  ph_eff = PH_TYPE_HI;
        default:      ph_eff = phase_q;
      endcase
    end
  end

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    skip_d  = skip_q;
    hi_d    = hi_q;
    lead_d  = lead_q;
    sni_d   = sni_q;
    fail_d  = fail_q;
    if (in_range) begin
      pos_d = pos_q + PosW'(1);
      if (pos_q < PosLead) begin
        lead_d = {lead_q[23:0], data_i};
      end
      if (!fail_q && phase_q != PH_DONE) begin
        phase_d = ph_eff;
        case (ph_eff)
          PH_HEADER: begin
            if ((pos_q == PosType && data_i != 8'h16) ||
                (pos_q == PosVersion && data_i != 8'h03) ||
                (pos_q == PosHsType && data_i != 8'h01)) begin
              fail_d = 1'b1;
            end else if (pos_q == PosSessLen) begin
              skip_d  = {8'd0, data_i};
              phase_d = PH_SESS_SKIP;
            end
          end
          PH_SESS_SKIP, PH_CIPH_SKIP, PH_COMP_SKIP, PH_EXT_SKIP: begin
            skip_d = skip_dec;
          end
          PH_CIPH_HI: begin
            hi_d    = data_i;
            phase_d = PH_CIPH_LO;
          end
          PH_CIPH_LO: begin
            skip_d  = {hi_q, data_i};
            phase_d = PH_CIPH_SKIP;
          end
          PH_COMP_LEN: begin
            skip_d  = {8'd0, data_i};
            phase_d = PH_COMP_SKIP;
          end
          PH_EXTS_HI: phase_d = PH_EXTS_LO;
          PH_EXTS_LO: phase_d = PH_TYPE_HI;
          PH_TYPE_HI: begin
            hi_d    = data_i;
            phase_d = PH_TYPE_LO;
          end
          PH_TYPE_LO: begin
            if (hi_q == 8'd0 && data_i == 8'd0) begin
              skip_d  = 16'd2;
              phase_d = PH_SNI_HDR;
            end else begin
              phase_d = PH_ELEN_HI;
            end
          end
          PH_ELEN_HI: begin
            hi_d    = data_i;
            phase_d = PH_ELEN_LO;
          end
          PH_ELEN_LO: begin
            skip_d  = {hi_q, data_i};
            phase_d = PH_EXT_SKIP;
          end
          PH_SNI_HDR: begin
            if (skip_q <= 16'd1) begin
              skip_d  = 16'd0;
              sni_d   = pos_q + PosW'(1);
              phase_d = PH_DONE;
            end else begin
              skip_d = skip_dec;
            end
          end
          default: phase_d = ph_eff;
        endcase
      end
    end
  end

  assign len_o     = pos_d;
  assign sni_o     = sni_d;
  assign leading_o = lead_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_HEADER;
      skip_q  <= '0;
      hi_q    <= '0;
      lead_q  <= '0;
      sni_q   <= '0;
      fail_q  <= 1'b0;
    end else if (accept_i && last_i) begin
      pos_q   <= '0;
      phase_q <= PH_HEADER;
      skip_q  <= '0;
      hi_q    <= '0;
      lead_q  <= '0;
      sni_q   <= '0;
      fail_q  <= 1'b0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      skip_q  <= skip_d;
      hi_q    <= hi_d;
      lead_q  <= lead_d;
      sni_q   <= sni_d;
      fail_q  <= fail_d;
    end
  end

  `TLSSNI_ASSERT(a_clear_after_last, accept_i && last_i |=> pos_q == '0 && sni_q == '0)
  `TLSSNI_ASSERT(a_sni_means_done, sni_q != '0 |-> phase_q == PH_DONE)
  `TLSSNI_ASSERT(a_pos_bounded, pos_q <= PosMax)

endmodule

`default_nettype wire

### rtl/core/tlssni_rule.sv
// split rule selection from the parsed packet summary and the settings
// depends on tlssni_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlssni_rule #(
  parameter int unsigned MAX_PACKET = tlssni_pkg::MaxPacket,
  localparam int unsigned PosW = $clog2(MAX_PACKET + 1)
) (
  input  wire logic [PosW-1:0] len_i,
  input  wire logic [PosW-1:0] sni_i,
  input  wire logic [31:0]     leading_i,
  input  wire tlssni_pkg::cfg_t cfg_i,
  output tlssni_pkg::result_t  result_o
);

  localparam int unsigned W = (PosW > tlssni_pkg::HttpW) ? PosW : tlssni_pkg::HttpW;

  logic [W-1:0] len_w, sni_w, http_w, fixed_w, split, split_c;
  logic         is_http, sni_found, http_pos, decoy_pos;
  tlssni_pkg::split_rule_e rule, rule_c;

  assign len_w   = W'(len_i);
  assign sni_w   = W'(sni_i);
  assign fixed_w = W'(cfg_i.fixed_offset);

  assign is_http = leading_i == tlssni_pkg::MethodGet ||
                   leading_i == tlssni_pkg::MethodPost ||
                   leading_i == tlssni_pkg::MethodHead;

  assign sni_found = sni_i != '0;
  assign http_pos  = !cfg_i.http_offset[tlssni_pkg::HttpW-1] && cfg_i.http_offset != '0;
  assign http_w    = http_pos ? W'(cfg_i.http_offset) : W'(2);
  assign decoy_pos = !cfg_i.decoy_ttl[tlssni_pkg::TtlW-1] && cfg_i.decoy_ttl != '0;

  always_comb begin
    split = '0;
    rule  = tlssni_pkg::RULE_NONE;
    if (sni_found && cfg_i.tls_enable) begin
      split = sni_w;
      rule  = tlssni_pkg::RULE_SNI;
    end else if (cfg_i.http_offset != '0 && len_w > W'(4) && is_http) begin
      split = http_w;
      rule  = tlssni_pkg::RULE_HTTP;
    end else if (fixed_w != '0 && len_w > fixed_w) begin
      split = fixed_w;
      rule  = tlssni_pkg::RULE_FIXED;
    end
    split_c = split;
    rule_c  = rule;
    if (split == '0 || split >= len_w) begin
      split_c = '0;
      rule_c  = tlssni_pkg::RULE_NONE;
    end
  end

  always_comb begin
    result_o.do_split       = split_c != '0;
    result_o.split_offset   = split_c[tlssni_pkg::FieldW-1:0];
    result_o.split_rule     = rule_c;
    result_o.send_decoy     = (split_c != '0) && decoy_pos;
    result_o.sni_found      = sni_found;
    result_o.payload_length = len_w[tlssni_pkg::FieldW-1:0];
  end

endmodule

`default_nettype wire

### rtl/core/tls_sni_split_point_finder.sv
// top level: settings registers, byte parser, rule selection, result register
// depends on tlssni_pkg, tlssni_parser, tlssni_rule and the macro header
//
//   channel   direction  handshake              payload
//   in        request    in_valid_i/in_stall_o  data_byte_i, last_byte_i
//   out       result     out_valid_o/out_stall_i  do_split_o .. payload_length_o
//   cfg       write      cfg_we_i               cfg_index_i, cfg_data_i
//
// one byte is taken every cycle while in_stall_o is low; the whole parse step sits between the
// parser state and the result register
// the result of a payload is registered and appears in the cycle after its last byte is taken
// no clearing pass: the block takes bytes from the first cycle after reset
// in_stall_o is high only while a result waits and out_stall_i is high
`timescale 1ns / 1ps
`default_nettype none
`include "tls_sni_split_point_finder_defines.svh"

module tls_sni_split_point_finder #(
  parameter int unsigned MAX_PACKET = tlssni_pkg::MaxPacket
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [7:0]                        data_byte_i,
  input  wire logic                              last_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   do_split_o,
  output logic [tlssni_pkg::FieldW-1:0]          split_offset_o,
  output logic [1:0]                             split_rule_o,
  output logic                                   send_decoy_o,
  output logic                                   sni_found_o,
  output logic [tlssni_pkg::FieldW-1:0]          payload_length_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [tlssni_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [tlssni_pkg::CfgW-1:0]       cfg_data_i
);

  localparam int unsigned PosW = $clog2(MAX_PACKET + 1);

  tlssni_pkg::cfg_t    cfg_q;
  tlssni_pkg::result_t res_d, res_q;
  logic                out_valid_q;
  logic                in_accept, last_accept;
  logic [PosW-1:0]     len, sni;
  logic [31:0]         leading;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign last_accept = in_accept && last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tls_enable   <= 1'b1;
      cfg_q.http_offset  <= tlssni_pkg::HttpW'(1);
      cfg_q.fixed_offset <= tlssni_pkg::FieldW'(1);
      cfg_q.decoy_ttl    <= tlssni_pkg::TtlW'(1);
    end else if (cfg_we_i) begin
      case (tlssni_pkg::cfg_index_e'(cfg_index_i))
        tlssni_pkg::CFG_TLS_ENABLE:   cfg_q.tls_enable   <= cfg_data_i[0];
        tlssni_pkg::CFG_HTTP_OFFSET:
          cfg_q.http_offset <= cfg_data_i[tlssni_pkg::HttpW-1:0];
        tlssni_pkg::CFG_FIXED_OFFSET:
          cfg_q.fixed_offset <= cfg_data_i[tlssni_pkg::FieldW-1:0];
        tlssni_pkg::CFG_DECOY_TTL:
          cfg_q.decoy_ttl <= cfg_data_i[tlssni_pkg::TtlW-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  tlssni_parser #(
    .MAX_PACKET(MAX_PACKET)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .data_i    (data_byte_i),
    .last_i    (last_byte_i),
    .len_o     (len),
    .sni_o     (sni),
    .leading_o (leading)
  );

  tlssni_rule #(
    .MAX_PACKET(MAX_PACKET)
  ) u_rule (
    .len_i     (len),
    .sni_i     (sni),
    .leading_i (leading),
    .cfg_i     (cfg_q),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign do_split_o       = res_q.do_split;
  assign split_offset_o   = res_q.split_offset;
  assign split_rule_o     = res_q.split_rule;
  assign send_decoy_o     = res_q.send_decoy;
  assign sni_found_o      = res_q.sni_found;
  assign payload_length_o = res_q.payload_length;

  `TLSSNI_ASSERT(a_result_after_last, last_accept |=> out_valid_q)
  `TLSSNI_ASSERT(a_rule_matches_split,
    out_valid_q |-> res_q.do_split == (res_q.split_rule != tlssni_pkg::RULE_NONE))
  `TLSSNI_ASSERT(a_decoy_needs_split, out_valid_q && res_q.send_decoy |-> res_q.do_split)

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for tls_sni_split_point_finder: streams payload bytes,
// predicts each split decision in a behavioural model and checks every result
// depends on tlssni_pkg and the tls_sni_split_point_finder rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int ClkPeriod = 4;
  localparam int QuietLimit = 400;
  localparam logic [7:0] RecordHandshake = 8'h16;
  localparam logic [7:0] RecordMajor = 8'h03;
  localparam logic [7:0] HandshakeHello = 8'h01;
  localparam int HelloFixedEnd = 43;

  typedef enum logic [3:0] {
    P_HEADER, P_SESSION, P_CIPHER_HI, P_CIPHER_LO, P_CIPHER_BODY,
    P_COMP_LEN, P_COMP_BODY, P_EXTLIST_HI, P_EXTLIST_LO, P_EXT_TYPE_HI,
    P_EXT_TYPE_LO, P_EXT_LEN_HI, P_EXT_LEN_LO, P_EXT_BODY, P_SNI_HEAD, P_DONE
  } hello_phase_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [7:0]                     data_byte_i = 8'h00;
  logic                           last_byte_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic                           do_split_o;
  logic [tlssni_pkg::FieldW-1:0]  split_offset_o;
  logic [1:0]                     split_rule_o;
  logic                           send_decoy_o;
  logic                           sni_found_o;
  logic [tlssni_pkg::FieldW-1:0]  payload_length_o;
  logic                           cfg_we_i = 1'b0;
  logic [tlssni_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [tlssni_pkg::CfgW-1:0]    cfg_data_i = '0;

  // register values the block should hold
  logic                                tls_enable_q = 1'b1;
  logic signed [tlssni_pkg::HttpW-1:0] http_offset_q = 14'sd1;
  logic [tlssni_pkg::FieldW-1:0]       fixed_offset_q = 13'd1;
  logic signed [tlssni_pkg::TtlW-1:0]  decoy_ttl_q = 9'sd1;

  // per-payload parser state
  int unsigned  seen_bytes = 0;
  hello_phase_e hello_phase = P_HEADER;
  int           skip_left = 0;
  logic [7:0]   len_high = 8'h00;
  logic [31:0]  leading_word = 32'h0;
  int           sni_offset = 0;
  bit           hello_broken = 1'b0;

  tlssni_pkg::result_t pending_decisions[$];
  tlssni_pkg::result_t head_decision;
  logic [7:0]          frame[$];

  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  int  bytes_sent = 0;
  int  hold_left = 0;
  int  burst_left = 0;
  bit  sender_gaps = 1'b1;
  bit  receiver_stalls = 1'b1;

  tls_sni_split_point_finder DUT (.*);

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_payload_state();
    seen_bytes = 0;
    hello_phase = P_HEADER;
    skip_left = 0;
    len_high = 8'h00;
    leading_word = 32'h0;
    sni_offset = 0;
    hello_broken = 1'b0;
  endfunction

  function automatic void step_hello_parser(input logic [7:0] b, input int p);
    if (skip_left == 0) begin
      case (hello_phase)
        P_SESSION:     hello_phase = P_CIPHER_HI;
        P_CIPHER_BODY: hello_phase = P_COMP_LEN;
        P_COMP_BODY:   hello_phase = P_EXTLIST_HI;
        P_EXT_BODY:    hello_phase = P_EXT_TYPE_HI;
        default: ;
      endcase
    end
    case (hello_phase)
      P_HEADER: begin
        if ((p == 0 && b != RecordHandshake) || (p == 1 && b != RecordMajor) ||
            (p == 5 && b != HandshakeHello)) begin
          hello_broken = 1'b1;
        end else if (p == HelloFixedEnd) begin
          skip_left = int'(b);
          hello_phase = P_SESSION;
        end
      end
      P_SESSION, P_CIPHER_BODY, P_COMP_BODY, P_EXT_BODY: skip_left--;
      P_CIPHER_HI: begin
        len_high = b;
        hello_phase = P_CIPHER_LO;
      end
      P_CIPHER_LO: begin
        skip_left = int'({len_high, b});
        hello_phase = P_CIPHER_BODY;
      end
      P_COMP_LEN: begin
        skip_left = int'(b);
        hello_phase = P_COMP_BODY;
      end
      P_EXTLIST_HI: hello_phase = P_EXTLIST_LO;
      P_EXTLIST_LO: hello_phase = P_EXT_TYPE_HI;
      P_EXT_TYPE_HI: begin
        len_high = b;
        hello_phase = P_EXT_TYPE_LO;
      end
      P_EXT_TYPE_LO: begin
        if (len_high == 8'h00 && b == 8'h00) begin
          skip_left = 2;
          hello_phase = P_SNI_HEAD;
        end else begin
          hello_phase = P_EXT_LEN_HI;
        end
      end
      P_EXT_LEN_HI: begin
        len_high = b;
        hello_phase = P_EXT_LEN_LO;
      end
      P_EXT_LEN_LO: begin
        skip_left = int'({len_high, b});
        hello_phase = P_EXT_BODY;
      end
      P_SNI_HEAD: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) begin
          sni_offset = p + 1;
          hello_phase = P_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic last);
    int                      len;
    int                      cut;
    tlssni_pkg::split_rule_e rule;
    logic                    is_http;
    tlssni_pkg::result_t     want;
    if (seen_bytes < tlssni_pkg::MaxPacket) begin
      if (seen_bytes < 4) leading_word = {leading_word[23:0], b};
      if (!hello_broken && hello_phase != P_DONE) step_hello_parser(b, seen_bytes);
      seen_bytes++;
    end
    if (last) begin
      len = seen_bytes;
      cut = 0;
      rule = tlssni_pkg::RULE_NONE;
      is_http = leading_word == tlssni_pkg::MethodGet ||
                leading_word == tlssni_pkg::MethodPost ||
                leading_word == tlssni_pkg::MethodHead;
      if (sni_offset > 0 && tls_enable_q) begin
        cut = sni_offset;
        rule = tlssni_pkg::RULE_SNI;
      end else if (http_offset_q != 0 && len > 4 && is_http) begin
        cut = (http_offset_q > 0) ? int'(http_offset_q) : 2;
        rule = tlssni_pkg::RULE_HTTP;
      end else if (fixed_offset_q > 0 && len > fixed_offset_q) begin
        cut = int'(fixed_offset_q);
        rule = tlssni_pkg::RULE_FIXED;
      end
      if (cut == 0 || cut >= len) begin
        cut = 0;
        rule = tlssni_pkg::RULE_NONE;
      end
      want.do_split = cut != 0;
      want.split_offset = cut[tlssni_pkg::FieldW-1:0];
      want.split_rule = rule;
      want.send_decoy = cut != 0 && decoy_ttl_q > 0;
      want.sni_found = sni_offset > 0;
      want.payload_length = len[tlssni_pkg::FieldW-1:0];
      pending_decisions.push_back(want);
      clear_payload_state();
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    $display("%0t: %s got %0d expected %0d", $time, field, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch("result with no request pending", 1, 0);
      end else begin
        head_decision = pending_decisions.pop_front();
        if (do_split_o !== head_decision.do_split)
          report_mismatch("do_split", do_split_o, head_decision.do_split);
        if (split_offset_o !== head_decision.split_offset)
          report_mismatch("split_offset", split_offset_o, head_decision.split_offset);
        if (split_rule_o !== head_decision.split_rule)
          report_mismatch("split_rule", split_rule_o, head_decision.split_rule);
        if (send_decoy_o !== head_decision.send_decoy)
          report_mismatch("send_decoy", send_decoy_o, head_decision.send_decoy);
        if (sni_found_o !== head_decision.sni_found)
          report_mismatch("sni_found", sni_found_o, head_decision.sni_found);
        if (payload_length_o !== head_decision.payload_length)
          report_mismatch("payload_length", payload_length_o, head_decision.payload_length);
      end
    end
  end

  // receiver: long holds on request, otherwise random bursts
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- driving

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    track_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    frame.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input tlssni_pkg::cfg_index_e idx, input int value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[tlssni_pkg::CfgW-1:0];
    case (idx)
      tlssni_pkg::CFG_TLS_ENABLE:   tls_enable_q = value[0];
      tlssni_pkg::CFG_HTTP_OFFSET:  http_offset_q = value[tlssni_pkg::HttpW-1:0];
      tlssni_pkg::CFG_FIXED_OFFSET: fixed_offset_q = value[tlssni_pkg::FieldW-1:0];
      tlssni_pkg::CFG_DECOY_TTL:    decoy_ttl_q = value[tlssni_pkg::TtlW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- payload builders

  task automatic add_random(input int n);
    repeat (n) frame.push_back(8'($urandom));
  endtask

  task automatic add_word(input logic [31:0] w);
    frame.push_back(w[31:24]);
    frame.push_back(w[23:16]);
    frame.push_back(w[15:8]);
    frame.push_back(w[7:0]);
  endtask

  task automatic build_hello(input int sess, input int ciph, input int comp, input int exts,
                             input bit with_sni, input int tail);
    logic [7:0] hi;
    logic [7:0] lo;
    frame.push_back(RecordHandshake);
    frame.push_back(RecordMajor);
    add_random(3);
    frame.push_back(HandshakeHello);
    add_random(HelloFixedEnd - 6);
    frame.push_back(8'(sess));
    add_random(sess);
    frame.push_back(8'(ciph >> 8));
    frame.push_back(8'(ciph));
    add_random(ciph);
    frame.push_back(8'(comp));
    add_random(comp);
    add_random(2);
    repeat (exts) begin
      hi = 8'($urandom);
      lo = 8'($urandom);
      if (hi == 8'h00 && lo == 8'h00) lo = 8'h2b;
      frame.push_back(hi);
      frame.push_back(lo);
      frame.push_back(8'h00);
      lo = 8'($urandom_range(0, 5));
      frame.push_back(lo);
      add_random(int'(lo));
    end
    if (with_sni) begin
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      add_random(2);
    end
    add_random(tail);
  endtask

  task automatic build_method(input int near_miss, input int tail);
    case ($urandom_range(0, 2))
      0: add_word(tlssni_pkg::MethodGet);
      1: add_word(tlssni_pkg::MethodPost);
      default: add_word(tlssni_pkg::MethodHead);
    endcase
    if (near_miss) frame[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    add_random(tail);
  endtask

  task automatic cut_frame();
    int keep;
    keep = $urandom_range(1, frame.size() - 1);
    frame = frame[0:keep-1];
  endtask

  task automatic break_header();
    int sel;
    sel = $urandom_range(0, 2);
    frame[sel == 0 ? 0 : (sel == 1 ? 1 : 5)] ^= 8'($urandom_range(1, 255));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    build_hello(0, 2, 1, 1, 1'b1, 5);
    send_frame();
    add_word(tlssni_pkg::MethodGet);
    add_random(6);
    send_frame();
    frame.push_back(8'h00);
    send_frame();
    frame.push_back(8'hff);
    add_random(2);
    send_frame();
  endtask

  task automatic test_tls_rule();
    write_reg(tlssni_pkg::CFG_TLS_ENABLE, 2);
    build_hello(0, 4, 1, 2, 1'b1, 6);
    send_frame();
    write_reg(tlssni_pkg::CFG_TLS_ENABLE, 1);
    // sni extension header ends exactly at the payload end
    build_hello(1, 2, 1, 1, 1'b1, 0);
    send_frame();
    build_hello(40, 2, 1, 0, 1'b1, 3);
    send_frame();
    build_hello(0, 2, 1, 3, 1'b1, 4);
    cut_frame();
    send_frame();
    build_hello(0, 2, 1, 1, 1'b1, 4);
    break_header();
    send_frame();
  endtask

  task automatic test_http_rule();
    write_reg(tlssni_pkg::CFG_FIXED_OFFSET, 0);
    write_reg(tlssni_pkg::CFG_HTTP_OFFSET, -1);
    add_word(tlssni_pkg::MethodPost);
    add_random(4);
    send_frame();
    write_reg(tlssni_pkg::CFG_HTTP_OFFSET, -4096);
    add_word(tlssni_pkg::MethodHead);
    add_random(1);
    send_frame();
    write_reg(tlssni_pkg::CFG_HTTP_OFFSET, 4096);
    add_word(tlssni_pkg::MethodGet);
    add_random(8);
    send_frame();
    write_reg(tlssni_pkg::CFG_HTTP_OFFSET, 0);
    add_word(tlssni_pkg::MethodGet);
    add_random(8);
    send_frame();
    write_reg(tlssni_pkg::CFG_HTTP_OFFSET, 3);
    write_reg(tlssni_pkg::CFG_FIXED_OFFSET, 1);
    add_word(tlssni_pkg::MethodHead);
    send_frame();
    build_method(1, 5);
    send_frame();
  endtask

  task automatic test_fixed_rule();
    write_reg(tlssni_pkg::CFG_HTTP_OFFSET, 0);
    write_reg(tlssni_pkg::CFG_FIXED_OFFSET, 0);
    add_random(10);
    send_frame();
    write_reg(tlssni_pkg::CFG_FIXED_OFFSET, 8191 | 16'h2000);
    add_random(10);
    send_frame();
    write_reg(tlssni_pkg::CFG_FIXED_OFFSET, 5);
    add_random(5);
    send_frame();
    add_random(6);
    send_frame();
  endtask

  task automatic test_decoy();
    write_reg(tlssni_pkg::CFG_FIXED_OFFSET, 2);
    write_reg(tlssni_pkg::CFG_DECOY_TTL, -1);
    add_random(6);
    send_frame();
    write_reg(tlssni_pkg::CFG_DECOY_TTL, 0);
    add_random(6);
    send_frame();
    write_reg(tlssni_pkg::CFG_DECOY_TTL, 255);
    add_random(6);
    send_frame();
    write_reg(tlssni_pkg::CFG_DECOY_TTL, -256);
    add_random(6);
    send_frame();
    write_reg(tlssni_pkg::CFG_DECOY_TTL, 1);
  endtask

  task automatic test_back_pressure();
    write_reg(tlssni_pkg::CFG_FIXED_OFFSET, 3);
    @(posedge clk_i);
    hold_left = 40;
    sender_gaps = 1'b0;
    repeat (6) begin
      add_random($urandom_range(1, 2));
      send_frame();
    end
    add_random(20);
    send_frame();
    // sender waits for every outstanding result
    wait_drained();
    sender_gaps = 1'b1;
  endtask

  task automatic shuffle_settings();
    int v;
    write_reg(tlssni_pkg::CFG_TLS_ENABLE, $urandom);
    case ($urandom_range(0, 6))
      0: v = 0;
      1: v = -1;
      2: v = -4096;
      3: v = 4096;
      4: v = $urandom_range(1, 40);
      5: v = $urandom;
      default: v = $urandom_range(1, 8);
    endcase
    write_reg(tlssni_pkg::CFG_HTTP_OFFSET, v);
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 1;
      2: v = 4096;
      3: v = 8191;
      4: v = $urandom;
      default: v = $urandom_range(1, 90);
    endcase
    write_reg(tlssni_pkg::CFG_FIXED_OFFSET, v);
    case ($urandom_range(0, 5))
      0: v = -1;
      1: v = 0;
      2: v = 255;
      3: v = -256;
      4: v = 1;
      default: v = $urandom;
    endcase
    write_reg(tlssni_pkg::CFG_DECOY_TTL, v);
  endtask

  task automatic test_random_traffic();
    int payloads;
    int kind;
    payloads = 0;
    while (bytes_sent < 650 || payloads < 2) begin
      if (payloads % 4 == 0) begin
        shuffle_settings();
        @(posedge clk_i);
        sender_gaps = $urandom_range(0, 3) != 0;
        receiver_stalls = $urandom_range(0, 3) != 0;
      end
      if (bytes_sent >= 600) begin
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        build_hello(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 0,
                    2 * $urandom_range(1, 8), $urandom_range(1, 2), $urandom_range(0, 3),
                    $urandom_range(0, 9) != 0, $urandom_range(0, 12));
        if (kind == 5) cut_frame();
        if (kind == 6) break_header();
      end else if (kind <= 8) begin
        build_method($urandom_range(0, 9) == 0, $urandom_range(0, 14));
      end else begin
        add_random($urandom_range(1, 12));
        if ($urandom_range(0, 1) == 0) frame[0] = RecordHandshake;
      end
      send_frame();
      payloads++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_tls_rule();
    test_http_rule();
    test_fixed_rule();
    test_decoy();
    test_back_pressure();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/tlssni_pkg.sv
rtl/core/tlssni_parser.sv
rtl/core/tlssni_rule.sv
rtl/core/tls_sni_split_point_finder.sv
tb/tb_top.sv
